### src/wsd_pkg.sv
package wsd_pkg;

    localparam int MAX_W      = 24;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 5;

    localparam logic [MAX_W-1:0] MAX_MSG_RESET = 24'h040000;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_RSV      = 3'd1;
    localparam logic [2:0] ERR_TOO_BIG  = 3'd2;
    localparam logic [2:0] ERR_BAD_CTRL = 3'd3;
    localparam logic [2:0] ERR_INTERLV  = 3'd4;
    localparam logic [2:0] ERR_ORPHAN   = 3'd5;
    localparam logic [2:0] ERR_RSV_OP   = 3'd6;

    // frame opcodes
    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // 7-bit length codes
    localparam logic [6:0] LEN16_CODE   = 7'd126;
    localparam logic [6:0] LEN64_CODE   = 7'd127;
    localparam logic [6:0] CTRL_MAX_LEN = 7'd125;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  payload_type;
        logic        has_byte;
        logic [7:0]  payload_byte;
        logic        last;
        logic [15:0] status_code;
        logic [2:0]  error_code;
    } res_t;

endpackage

### src/wsd_parser.sv
module wsd_parser
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [MAX_W-1:0] cfg_data,
    input  logic             step,
    input  logic [7:0]       wire_byte,
    output logic             res_valid,
    output res_t             res
);

    localparam int LB   = LENGTH_BITS;
    localparam int LIMW = (LB > MAX_W) ? LB : MAX_W;
    localparam logic [LIMW-1:0] LEN_MAX = LIMW'((64'd1 << LB) - 64'd1);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_PAY,
        PH_CLOSED,
        PH_FAILED
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic             fin_reg, fin_next;
    logic [3:0]       op_reg, op_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [LB-1:0]    acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic             mask_reg, mask_next;
    logic [31:0]      key_reg, key_next;
    logic [LB-1:0]    idx_reg, idx_next;
    logic             frag_active_reg, frag_active_next;
    logic [1:0]       frag_type_reg, frag_type_next;
    logic [LB-1:0]    frag_len_reg, frag_len_next;
    logic [15:0]      close_reg, close_next;
    logic [MAX_W-1:0] max_reg;

    logic [LB+7:0]    ext_cat;
    logic [LB-1:0]    len_eval;
    logic             ovf_eval;
    logic [LIMW-1:0]  lim;
    logic [LIMW:0]    frag_sum;
    logic [2:0]       chk_err;
    logic [7:0]       key_byte;
    logic [7:0]       pay_byte;
    logic [LB:0]      idx_inc;
    logic             pay_end;
    logic [1:0]       dtype;
    logic             do_hdr_done;
    logic             do_start;
    logic             finish;
    logic             empty;

    assign ext_cat = {acc_reg, wire_byte};

    always_comb
    begin
        case (phase_reg)
            PH_HDR1:
            begin
                len_eval = LB'(wire_byte[6:0]);
                ovf_eval = 1'b0;
            end
            PH_EXT:
            begin
                len_eval = ext_cat[LB-1:0];
                ovf_eval = ovf_reg | (|ext_cat[LB+7:LB]);
            end
            default:
            begin
                len_eval = acc_reg;
                ovf_eval = ovf_reg;
            end
        endcase
    end

    assign lim      = (LIMW'(max_reg) > LEN_MAX) ? LEN_MAX : LIMW'(max_reg);
    assign frag_sum = (LIMW+1)'(frag_len_reg) + (LIMW+1)'(len_eval);

    // header checks, in precedence order
    always_comb
    begin
        if (ovf_eval || (LIMW'(len_eval) > lim))
            chk_err = ERR_TOO_BIG;
        else if (op_reg[3])
            chk_err = (!fin_reg || len_eval > LB'(CTRL_MAX_LEN)) ? ERR_BAD_CTRL : ERR_NONE;
        else if (op_reg == OP_TEXT || op_reg == OP_BIN)
            chk_err = frag_active_reg ? ERR_INTERLV : ERR_NONE;
        else if (op_reg == OP_CONT)
        begin
            if (!frag_active_reg)
                chk_err = ERR_ORPHAN;
            else if (frag_sum > (LIMW+1)'(lim))
                chk_err = ERR_TOO_BIG;
            else
                chk_err = ERR_NONE;
        end
        else
            chk_err = ERR_RSV_OP;
    end

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign pay_byte = mask_reg ? (wire_byte ^ key_byte) : wire_byte;
    assign idx_inc  = {1'b0, idx_reg} + (LB+1)'(1);
    assign pay_end  = idx_inc >= {1'b0, acc_reg};
    assign dtype    = (op_reg == OP_CONT) ? frag_type_reg : op_reg[1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        fin_next         = fin_reg;
        op_next          = op_reg;
        cnt_next         = cnt_reg;
        acc_next         = acc_reg;
        ovf_next         = ovf_reg;
        mask_next        = mask_reg;
        key_next         = key_reg;
        idx_next         = idx_reg;
        frag_active_next = frag_active_reg;
        frag_type_next   = frag_type_reg;
        frag_len_next    = frag_len_reg;
        close_next       = close_reg;
        res_valid        = 1'b0;
        res              = '0;
        do_hdr_done      = 1'b0;
        do_start         = 1'b0;
        finish           = 1'b0;
        empty            = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_HDR1:
                begin
                    mask_next = wire_byte[7];
                    ovf_next  = 1'b0;
                    if (wire_byte[6:0] == LEN16_CODE || wire_byte[6:0] == LEN64_CODE)
                    begin
                        acc_next   = '0;
                        cnt_next   = (wire_byte[6:0] == LEN16_CODE) ? EXT16_BYTES
                                                                    : EXT64_BYTES;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        acc_next    = len_eval;
                        do_hdr_done = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    acc_next = len_eval;
                    ovf_next = ovf_eval;
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                        do_hdr_done = 1'b1;
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], wire_byte};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                        do_start = 1'b1;
                end
                PH_PAY:
                begin
                    if (op_reg == OP_CLOSE)
                    begin
                        // collect the big-endian status code
                        if (idx_reg == '0)
                            close_next = {pay_byte, 8'h00};
                        else if (idx_reg == LB'(1))
                            close_next = close_reg | {8'h00, pay_byte};
                    end
                    else if (op_reg == OP_PING)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PING;
                        res.has_byte     = 1'b1;
                        res.payload_byte = pay_byte;
                        res.last         = pay_end;
                    end
                    else if (op_reg <= OP_BIN)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_DATA;
                        res.payload_type = dtype;
                        res.has_byte     = 1'b1;
                        res.payload_byte = pay_byte;
                        res.last         = pay_end & fin_reg;
                    end
                    if (pay_end)
                        finish = 1'b1;
                    else
                        idx_next = idx_inc[LB-1:0];
                end
                PH_CLOSED, PH_FAILED:
                begin
                    // drop every byte until reset
                end
                default:
                begin
                    if (wire_byte[6:4] != 3'b000)
                    begin
                        phase_next     = PH_FAILED;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_RSV;
                    end
                    else
                    begin
                        fin_next   = wire_byte[7];
                        op_next    = wire_byte[3:0];
                        phase_next = PH_HDR1;
                    end
                end
            endcase

            if (do_hdr_done)
            begin
                if (chk_err != ERR_NONE)
                begin
                    phase_next     = PH_FAILED;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = chk_err;
                end
                else if (mask_next)
                begin
                    cnt_next   = MASK_BYTES;
                    key_next   = '0;
                    phase_next = PH_MASK;
                end
                else
                    do_start = 1'b1;
            end

            if (do_start)
            begin
                idx_next   = '0;
                close_next = '0;
                if (len_eval == '0 && !ovf_eval)
                begin
                    finish = 1'b1;
                    empty  = 1'b1;
                end
                else
                    phase_next = PH_PAY;
            end

            if (finish)
            begin
                phase_next = PH_HDR0;
                if (op_reg == OP_CLOSE)
                begin
                    phase_next      = PH_CLOSED;
                    res_valid       = 1'b1;
                    res.kind        = KIND_CLOSE;
                    res.status_code = (len_eval >= LB'(2)) ? close_next : 16'h0000;
                end
                else if (op_reg == OP_PING)
                begin
                    if (empty)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_PING;
                        res.last  = 1'b1;
                    end
                end
                else if (op_reg <= OP_BIN)
                begin
                    if (empty && fin_reg)
                    begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_DATA;
                        res.payload_type = dtype;
                        res.last         = 1'b1;
                    end
                    if (op_reg == OP_CONT)
                    begin
                        if (fin_reg)
                        begin
                            frag_active_next = 1'b0;
                            frag_type_next   = 2'd0;
                            frag_len_next    = '0;
                        end
                        else
                            frag_len_next = frag_len_reg + len_eval;
                    end
                    else if (!fin_reg)
                    begin
                        frag_active_next = 1'b1;
                        frag_type_next   = op_reg[1:0];
                        frag_len_next    = len_eval;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            fin_reg         <= 1'b0;
            op_reg          <= '0;
            cnt_reg         <= '0;
            acc_reg         <= '0;
            ovf_reg         <= 1'b0;
            mask_reg        <= 1'b0;
            key_reg         <= '0;
            idx_reg         <= '0;
            frag_active_reg <= 1'b0;
            frag_type_reg   <= '0;
            frag_len_reg    <= '0;
            close_reg       <= '0;
            max_reg         <= MAX_MSG_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            fin_reg         <= fin_next;
            op_reg          <= op_next;
            cnt_reg         <= cnt_next;
            acc_reg         <= acc_next;
            ovf_reg         <= ovf_next;
            mask_reg        <= mask_next;
            key_reg         <= key_next;
            idx_reg         <= idx_next;
            frag_active_reg <= frag_active_next;
            frag_type_reg   <= frag_type_next;
            frag_len_reg    <= frag_len_next;
            close_reg       <= close_next;
            if (cfg_we)
                max_reg <= cfg_data;
        end
    end

`ifndef SYNTHESIS
    a_no_result_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FAILED || phase_reg == PH_CLOSED) |-> !res_valid)
        else $error("result after close or failure");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_ERROR) |-> (res.error_code != ERR_NONE))
        else $error("error result without a code");

    a_frag_type: assert property (@(posedge clk) disable iff (!rst_n)
        frag_active_reg |-> (frag_type_reg == OP_TEXT[1:0] || frag_type_reg == OP_BIN[1:0]))
        else $error("open fragment with bad type");

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (idx_reg < acc_reg))
        else $error("payload index past frame length");
`endif

endmodule

### src/wsd_out_stage.sv
module wsd_out_stage
    import wsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  load_valid,
    input  res_t                  load_res,
    output logic                  can_take,
    output logic                  tvalid,
    input  logic                  tready,
    output logic [OUT_DATA_W-1:0] tdata,
    output logic [OUT_USER_W-1:0] tuser,
    output logic                  tlast
);

    logic valid_reg;
    res_t res_reg;

    assign can_take = !valid_reg || tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= load_valid;
        else if (tready)
            valid_reg <= 1'b0;
    end

    // hold the beat until taken
    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            res_reg <= load_res;
    end

    assign tvalid = valid_reg;
    assign tdata  = {5'b00000, res_reg.error_code, res_reg.status_code, res_reg.payload_byte};
    assign tuser  = {res_reg.has_byte, res_reg.payload_type, res_reg.kind};
    assign tlast  = res_reg.last;

endmodule

### src/websocket_frame_deframer.sv
// channel   dir  beat fields (low bit up)
// s_axis    in   tdata: wire_byte[7:0]
// m_axis    out  tdata: payload_byte[7:0], status_code[23:8], error_code[26:24]
//                tuser: kind[1:0], payload_type[3:2], has_byte[4]; tlast: last
// cfg       in   cfg_we / cfg_data: max_message_bytes[23:0]
//
// One wire byte per cycle sustained while the output is not stalled: a byte is
// held in the input register, the parser updates its state and forms the result
// combinationally, and the result is loaded into the output register on that step.
// Reset returns the parser to the first header byte and restores the limit.
// A stalled output holds one beat while one more input byte waits in the
// input register; then s_axis_tready drops.
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [MAX_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // wire_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // payload_byte, status_code, error_code
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // kind, payload_type, has_byte
    output logic                  m_axis_tlast
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       can_take;
    logic       step;
    logic       res_valid;
    res_t       res;

    assign step          = in_valid_reg && can_take;
    assign s_axis_tready = !in_valid_reg || can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    wsd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .step      (step),
        .wire_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_valid (res_valid),
        .load_res   (res),
        .can_take   (can_take),
        .tvalid     (m_axis_tvalid),
        .tready     (m_axis_tready),
        .tdata      (m_axis_tdata),
        .tuser      (m_axis_tuser),
        .tlast      (m_axis_tlast)
    );

endmodule
